// ===== hw/rtl/plc_pkg.sv =====
package plc_pkg;

  localparam int KEY_W  = 128;
  localparam int HALF_W = 64;
  localparam int CNT_W  = 16;
  localparam int TRK_W  = 7;
  localparam int STS_W  = 2;

  localparam logic [CNT_W-1:0] MAX_RESET = 16'd16;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } plc_status_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key;
  } plc_entry_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic commit;
  } plc_cmd_t;

endpackage

// ===== hw/rtl/plc_if.sv =====
interface plc_in_if import plc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [HALF_W-1:0] address_high;
  logic [HALF_W-1:0] address_low;

  modport source (output valid, output operation, output address_high,
                  output address_low, input ready);
  modport sink (input valid, input operation, input address_high,
                input address_low, output ready);
endinterface

interface plc_out_if import plc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [CNT_W-1:0] address_count;
  logic [TRK_W-1:0] tracked_addresses;

  modport source (output valid, output status, output address_count,
                  output tracked_addresses, input ready);
  modport sink (input valid, input status, input address_count,
                input tracked_addresses, output ready);
endinterface

interface plc_cfg_if import plc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] max_per_address;

  modport source (output valid, output max_per_address, input ready);
  modport sink (input valid, input max_per_address, output ready);
endinterface

// ===== hw/rtl/plc_dp.sv =====
module plc_dp import plc_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int AW            = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  plc_cmd_t          cmd,
  input  logic [AW-1:0]     addr,
  input  logic              in_operation,
  input  logic [HALF_W-1:0] in_address_high,
  input  logic [HALF_W-1:0] in_address_low,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_max_per_address,
  output logic [STS_W-1:0]  out_status,
  output logic [CNT_W-1:0]  out_address_count,
  output logic [TRK_W-1:0]  out_tracked_addresses
);

  localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

  plc_entry_t mem [TABLE_ENTRIES];

  logic [CNT_W-1:0] max_r;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  plc_entry_t       rd_word_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_idx_r;
  logic             match_r;
  logic [AW-1:0]    match_idx_r;
  logic [CNT_W-1:0] match_cnt_r;
  logic             free_r;
  logic [AW-1:0]    free_idx_r;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic [STS_W-1:0] status_r;
  logic [CNT_W-1:0] count_r;
  logic [TRK_W-1:0] tracked_r;

  plc_status_t      sts;
  logic [CNT_W-1:0] res_cnt;
  logic [CNT_W-1:0] dec_cnt;
  logic             wr_need;
  logic [AW-1:0]    wr_idx;
  plc_entry_t       wr_word;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  plc_entry_t       mem_wdata;

  assign dec_cnt = match_cnt_r - 16'd1;

  always_comb begin
    sts     = ST_OK;
    res_cnt = '0;
    wr_need = 1'b0;
    wr_idx  = match_idx_r;
    wr_word = '{valid: 1'b1, count: match_cnt_r, key: key_r};
    occ_nxt = occ_r;
    if (op_r == OP_OPEN) begin
      if (match_r) begin
        if (match_cnt_r >= max_r) begin
          sts     = ST_LIMIT;
          res_cnt = match_cnt_r;
        end else begin
          res_cnt       = match_cnt_r + 16'd1;
          wr_need       = 1'b1;
          wr_word.count = match_cnt_r + 16'd1;
        end
      end else if (max_r == '0) begin
        sts = ST_LIMIT;
      end else if (!free_r) begin
        sts = ST_FULL;
      end else begin
        res_cnt       = 16'd1;
        wr_need       = 1'b1;
        wr_idx        = free_idx_r;
        wr_word.count = 16'd1;
        occ_nxt       = occ_r + OCC_W'(1);
      end
    end else begin
      if (!match_r) begin
        sts = ST_UNKNOWN;
      end else begin
        res_cnt       = dec_cnt;
        wr_need       = 1'b1;
        wr_word.count = dec_cnt;
        wr_word.valid = (dec_cnt != '0);
        if (dec_cnt == '0) begin
          occ_nxt = occ_r - OCC_W'(1);
        end
      end
    end
  end

  always_comb begin
    mem_we    = cmd.clear | (cmd.commit & wr_need);
    mem_waddr = cmd.clear ? addr : wr_idx;
    mem_wdata = cmd.clear ? plc_entry_t'('0) : wr_word;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.scan) begin
      rd_word_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      key_r <= {in_address_high, in_address_low};
    end
    rd_idx_r <= addr;
    if (rd_vld_r && rd_word_r.valid && rd_word_r.key == key_r) begin
      match_idx_r <= rd_idx_r;
      match_cnt_r <= rd_word_r.count;
    end
    if (rd_vld_r && !rd_word_r.valid && !free_r) begin
      free_idx_r <= rd_idx_r;
    end
    if (cmd.commit) begin
      status_r  <= sts;
      count_r   <= res_cnt;
      tracked_r <= TRK_W'(32'(occ_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= MAX_RESET;
      rd_vld_r <= 1'b0;
      match_r  <= 1'b0;
      free_r   <= 1'b0;
      occ_r    <= '0;
    end else begin
      if (cfg_valid) begin
        max_r <= cfg_max_per_address;
      end
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        match_r <= 1'b0;
        free_r  <= 1'b0;
      end else if (rd_vld_r) begin
        if (rd_word_r.valid && rd_word_r.key == key_r) begin
          match_r <= 1'b1;
        end
        if (!rd_word_r.valid) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        occ_r <= occ_nxt;
      end
    end
  end

  assign out_status            = status_r;
  assign out_address_count     = count_r;
  assign out_tracked_addresses = tracked_r;

endmodule

// ===== hw/rtl/plc_ctrl.sv =====
module plc_ctrl import plc_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int AW            = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output plc_cmd_t      cmd,
  output logic [AW-1:0] addr
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t        state_r;
  logic [AW-1:0] idx_r;
  logic          out_valid_r;
  logic          last;
  logic          out_free;

  assign last     = (idx_r == AW'(TABLE_ENTRIES - 1));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.clear  = (state_r == S_CLEAR);
    cmd.scan   = (state_r == S_SCAN);
    cmd.commit = (state_r == S_COMMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= last ? '0 : idx_r + AW'(1);
          if (last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx_r <= '0;
          if (in_valid) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx_r <= last ? '0 : idx_r + AW'(1);
          if (last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign addr      = idx_r;

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.clear, cmd.scan, cmd.commit}))
    else $error("controller issued overlapping commands");

  a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.scan && idx_r == '0)
    else $error("scan did not start at entry zero after load");

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before it was taken");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && state_r == S_IDLE)
    else $error("committed result not presented");

  a_scan_drains: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan && last |=> state_r == S_DRAIN ##1 state_r == S_COMMIT)
    else $error("scan end not followed by drain and commit");

endmodule

// ===== hw/rtl/per_ip_connection_limiter.sv =====
// Per-address connection limiter. Each open or close item carries a 128-bit
// address key and produces one result with a status, the address's count
// and the number of tracked addresses. The table of TABLE_ENTRIES entries
// sits in one memory with one read and one write port. Each item scans the
// table one entry per cycle, then passes through a drain state for the last
// read and a commit state, where the result is registered. The next item is
// accepted only after that commit, so no item is taken while another is in
// flight. A result that is not taken holds the commit of the next item until
// it is taken. After reset the block clears the table entry by entry and
// accepts no item until the clear is done. Limit writes on the cfg_ channel
// are taken at any time and must only be issued while no item is in flight.
module per_ip_connection_limiter import plc_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  plc_in_if.sink        in_item,
  plc_out_if.source     out_item,
  plc_cfg_if.sink       cfg_wr
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  plc_cmd_t      cmd;
  logic [AW-1:0] addr;

  assign cfg_wr.ready = 1'b1;

  plc_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AW           (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .out_valid(out_item.valid),
    .out_ready(out_item.ready),
    .cmd      (cmd),
    .addr     (addr)
  );

  plc_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AW           (AW)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .addr                 (addr),
    .in_operation         (in_item.operation),
    .in_address_high      (in_item.address_high),
    .in_address_low       (in_item.address_low),
    .cfg_valid            (cfg_wr.valid),
    .cfg_max_per_address  (cfg_wr.max_per_address),
    .out_status           (out_item.status),
    .out_address_count    (out_item.address_count),
    .out_tracked_addresses(out_item.tracked_addresses)
  );

endmodule

// ===== sim/per_ip_connection_limiter_tb.sv =====
`timescale 1ns / 100ps

module per_ip_connection_limiter_tb;
  import plc_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int POOL_SIZE     = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = TABLE_ENTRIES + 8;

  localparam logic [KEY_W-1:0] KEY_ZERO  = '0;
  localparam logic [KEY_W-1:0] KEY_ONES  = '1;
  localparam logic [KEY_W-1:0] KEY_SPLIT = {{HALF_W{1'b1}}, {HALF_W{1'b0}}};
  localparam logic [KEY_W-1:0] KEY_V4    = {96'd0, 32'hC0A8_0001};

  typedef struct {
    logic              op;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } conn_req_t;

  typedef struct {
    plc_status_t      status;
    logic [CNT_W-1:0] count;
    logic [TRK_W-1:0] tracked;
  } conn_res_t;

  logic clk;
  logic rst_n;

  plc_in_if  in_item ();
  plc_out_if out_item ();
  plc_cfg_if cfg_wr ();

  per_ip_connection_limiter #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg_wr   (cfg_wr)
  );

  logic             slot_used  [TABLE_ENTRIES];
  logic [KEY_W-1:0] slot_key   [TABLE_ENTRIES];
  logic [CNT_W-1:0] slot_count [TABLE_ENTRIES];
  int               slots_taken;
  logic [CNT_W-1:0] conn_limit;

  logic [KEY_W-1:0] addr_pool [POOL_SIZE];
  conn_req_t        queued_requests [$];
  conn_res_t        pending_results [$];

  bit in_took;
  bit tx_busy;
  bit calm;
  int tx_gap;
  int rx_stall;
  int rx_hold;
  int hold_asked;
  int hold_given;
  int errors;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic conn_res_t admit_or_release(conn_req_t req);
    conn_res_t        res;
    logic [KEY_W-1:0] key;
    int               hit;
    int               spare;
    key   = {req.hi, req.lo};
    hit   = -1;
    spare = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) hit = i;
      if (!slot_used[i]) spare = i;
    end
    res.status = ST_OK;
    res.count  = '0;
    if (req.op == OP_OPEN) begin
      if (hit >= 0) begin
        if (slot_count[hit] >= conn_limit) res.status = ST_LIMIT;
        else slot_count[hit] = slot_count[hit] + CNT_W'(1);
        res.count = slot_count[hit];
      end else if (conn_limit == '0) begin
        res.status = ST_LIMIT;
      end else if (spare < 0) begin
        res.status = ST_FULL;
      end else begin
        slot_used[spare]  = 1'b1;
        slot_key[spare]   = key;
        slot_count[spare] = CNT_W'(1);
        slots_taken++;
        res.count = CNT_W'(1);
      end
    end else if (hit < 0) begin
      res.status = ST_UNKNOWN;
    end else begin
      slot_count[hit] = slot_count[hit] - CNT_W'(1);
      res.count = slot_count[hit];
      if (slot_count[hit] == '0) begin
        slot_used[hit] = 1'b0;
        slots_taken--;
      end
    end
    res.tracked = TRK_W'(slots_taken);
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  always @(posedge clk) begin : watch_ports
    conn_req_t req;
    conn_res_t want;
    in_took = 1'b0;
    if (rst_n === 1'b1) begin
      if (cfg_wr.valid && cfg_wr.ready) conn_limit = cfg_wr.max_per_address;
      if (in_item.valid && in_item.ready) begin
        in_took = 1'b1;
        req.op  = in_item.operation;
        req.hi  = in_item.address_high;
        req.lo  = in_item.address_low;
        pending_results.push_back(admit_or_release(req));
      end
      if (out_item.valid && out_item.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected item: status %0d, address_count %0d, tracked_addresses %0d",
                 out_item.status, out_item.address_count, out_item.tracked_addresses);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.address_count !== want.count) begin
            $error("address_count: expected %0d, got %0d", want.count,
                   out_item.address_count);
            errors++;
          end
          if (out_item.tracked_addresses !== want.tracked) begin
            $error("tracked_addresses: expected %0d, got %0d", want.tracked,
                   out_item.tracked_addresses);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : send_requests
    conn_req_t req;
    if (rst_n !== 1'b1) begin
      in_item.valid <= 1'b0;
      tx_busy = 1'b0;
      tx_gap  = 0;
    end else if (tx_busy && !in_took) begin
      // hold the item until taken
    end else begin
      tx_busy = 1'b0;
      if (tx_gap > 0) begin
        in_item.valid <= 1'b0;
        tx_gap--;
      end else if (queued_requests.size() > 0) begin
        req = queued_requests.pop_front();
        in_item.valid        <= 1'b1;
        in_item.operation    <= req.op;
        in_item.address_high <= req.hi;
        in_item.address_low  <= req.lo;
        tx_busy = 1'b1;
        tx_gap  = idle_len();
      end else begin
        in_item.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : take_results
    if (rst_n !== 1'b1) begin
      out_item.ready <= 1'b0;
      rx_stall = 0;
      rx_hold  = 0;
    end else if (rx_hold > 0) begin
      out_item.ready <= 1'b0;
      rx_hold--;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      rx_hold = HOLD_CYCLES - 1;
      out_item.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      out_item.ready <= 1'b0;
      rx_stall--;
    end else begin
      out_item.ready <= 1'b1;
      rx_stall = idle_len();
    end
  end

  task automatic offer(input logic op, input logic [KEY_W-1:0] key);
    conn_req_t req;
    req.op = op;
    req.hi = key[KEY_W-1:HALF_W];
    req.lo = key[HALF_W-1:0];
    queued_requests.push_back(req);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (queued_requests.size() != 0 || tx_busy || pending_results.size() != 0);
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr.valid           <= 1'b1;
    cfg_wr.max_per_address <= value;
    do @(posedge clk);
    while (cfg_wr.ready !== 1'b1);
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] limit, input int pool_n, input int n,
                           input int open_pct, input bit quiet, input bit long_hold);
    logic [KEY_W-1:0] key;
    set_limit(limit);
    calm = quiet;
    if (long_hold) hold_asked++;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) key = {$urandom, $urandom, $urandom, $urandom};
      else key = addr_pool[$urandom_range(pool_n - 1)];
      offer(($urandom_range(99) < open_pct) ? OP_OPEN : OP_CLOSE, key);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    rst_n                  = 1'b0;
    calm                   = 1'b0;
    hold_asked             = 0;
    hold_given             = 0;
    errors                 = 0;
    in_took                = 1'b0;
    in_item.valid          = 1'b0;
    in_item.operation      = OP_OPEN;
    in_item.address_high   = '0;
    in_item.address_low    = '0;
    out_item.ready         = 1'b0;
    cfg_wr.valid           = 1'b0;
    cfg_wr.max_per_address = '0;
    conn_limit             = MAX_RESET;
    slots_taken            = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_used[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_count[i] = '0;
    end
    for (int k = 0; k < POOL_SIZE; k++) begin
      case (k % 4)
        0: addr_pool[k] = {96'd0, $urandom};
        1: addr_pool[k] = {$urandom, $urandom, $urandom, $urandom};
        2: addr_pool[k] = addr_pool[k-1] ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
        default: addr_pool[k] = ~addr_pool[k-2];
      endcase
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer(OP_OPEN, KEY_ZERO);
    offer(OP_OPEN, KEY_ONES);
    offer(OP_OPEN, KEY_ZERO);
    offer(OP_CLOSE, KEY_SPLIT);
    offer(OP_CLOSE, KEY_ZERO);
    offer(OP_CLOSE, KEY_ZERO);
    offer(OP_CLOSE, KEY_ZERO);
    offer(OP_OPEN, KEY_V4);
    set_limit('0);
    offer(OP_OPEN, KEY_SPLIT);
    offer(OP_OPEN, KEY_ONES);
    offer(OP_CLOSE, KEY_ONES);
    set_limit(CNT_W'(2));
    offer(OP_OPEN, KEY_V4);
    offer(OP_OPEN, KEY_V4);
    set_limit(CNT_W'(1));
    offer(OP_OPEN, KEY_V4);
    offer(OP_CLOSE, KEY_V4);
    offer(OP_OPEN, KEY_V4);
    offer(OP_CLOSE, KEY_V4);

    run_phase(CNT_W'(3), 8, 60, 60, 1'b0, 1'b0);
    run_phase(CNT_W'(1), 5, 40, 55, 1'b1, 1'b0);
    run_phase('1, POOL_SIZE, 150, 95, 1'b0, 1'b0);
    run_phase('0, POOL_SIZE, 40, 60, 1'b0, 1'b0);
    run_phase(CNT_W'(2), POOL_SIZE, 80, 15, 1'b0, 1'b0);
    run_phase(MAX_RESET, 12, 60, 65, 1'b0, 1'b1);
    run_phase(CNT_W'(4), 6, 40, 50, 1'b1, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
